[design/byte_stream_crc_hash_unit_defines.svh]
// assertion macros for the byte stream crc hash unit
`ifndef BYTE_STREAM_CRC_HASH_UNIT_DEFINES_SVH
`define BYTE_STREAM_CRC_HASH_UNIT_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define BSCH_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked at every rising clock edge out of reset
`define BSCH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/bsch_pkg.sv]
package bsch_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned PolyWidth = 24;
   localparam int unsigned AccWidth  = 32;

   localparam logic [PolyWidth-1:0] PolyReset = 24'h864CFB;

   // one byte held in the input register
   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [ByteWidth-1:0] data;
   } stage_type;

   // carry-less product of an 8-bit index and the 24-bit polynomial (31 bits max)
   function automatic logic [AccWidth-1:0] clmul_entry(
      input logic [ByteWidth-1:0] idx,
      input logic [PolyWidth-1:0] poly
   );
      logic [AccWidth-1:0] prod;
      prod = '0;
      for (int b = 0; b < ByteWidth; b++) begin
         if (idx[b]) begin
            prod = prod ^ ({{(AccWidth-PolyWidth){1'b0}}, poly} << b);
         end
      end
      return prod;
   endfunction

endpackage

[design/byte_stream_crc_hash_unit.sv]
// Byte stream CRC hash: MSB-first, table-driven 32-bit hash of a byte message.
// Input channel (req_valid / req_stall): one message byte per transfer, with
// req_last_byte marking the final byte. Every message has at least one byte.
// Result channel (rsp_valid / rsp_stall): one 32-bit hash per message, sent
// after its last byte; bytes that are not last produce nothing.
// Configuration: csr_write_enable loads csr_write_data as the 24-bit
// polynomial; write it only while no message is in flight.
// Path: a last byte moves from the input register into the result register,
// which drives rsp_valid. Throughput: one byte per cycle while no last byte
// is held back by a busy result register; the accumulator is updated from
// the input register once for each byte that moves on.
// Reset clears the accumulator and both registers' valid bits and sets the
// polynomial to 0x864CFB.
// While the receiver stalls, the held result stays put; bytes that are not
// last keep flowing, and a last byte waits in the input register, which
// raises req_stall until the result register frees up.
`include "byte_stream_crc_hash_unit_defines.svh"

module byte_stream_crc_hash_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value,
   input  logic        csr_write_enable,
   input  logic [23:0] csr_write_data
);
   import bsch_pkg::*;

   stage_type            stage;
   logic                 advance;
   logic                 rsp_ready;
   logic [AccWidth-1:0]  hash_next;
   logic [PolyWidth-1:0] poly_ff;

   // polynomial register
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= PolyReset;
      end else if (csr_write_enable) begin
         poly_ff <= csr_write_data;
      end
   end

   // a held byte moves on unless it is last and the result slot is busy
   assign advance = stage.valid && (!stage.last || rsp_ready);

   bsch_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .advance       (advance),
      .stage         (stage)
   );

   bsch_update u_update (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .advance   (advance),
      .poly      (poly_ff),
      .hash_next (hash_next)
   );

   bsch_rsp_buf u_rsp_buf (
      .clock          (clock),
      .reset          (reset),
      .load           (advance && stage.last),
      .hash_in        (hash_next),
      .ready          (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hash_value (rsp_hash_value)
   );

   // checks
   `BSCH_ASSERT_NEXT(a_last_gives_rsp, advance && stage.last, rsp_valid, "last byte gave no result")
   `BSCH_ASSERT_NEXT(a_rsp_value, advance && stage.last, rsp_hash_value == $past(hash_next), "result does not match accumulator")
   `BSCH_ASSERT_NOW(a_stall_when_held, req_stall, stage.valid && stage.last && !rsp_ready, "input stalled without a blocked last byte")
   `BSCH_ASSERT_NEXT(a_no_extra_rsp, rsp_valid && !rsp_stall && !(advance && stage.last), !rsp_valid, "result appeared without a last byte")

endmodule

[design/bsch_in_stage.sv]
module bsch_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_last_byte,
   input  logic                       advance,
   output bsch_pkg::stage_type        stage
);
   import bsch_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   logic                 last_ff;
   logic [ByteWidth-1:0] data_ff;
   logic                 load;

   // the register frees up when empty or when its byte moves on this cycle
   assign load      = !valid_ff || advance;
   assign req_stall = !load;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   // control bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload capture on an input transfer
   always_ff @(posedge clock) begin
      if (req_valid && load) begin
         last_ff <= req_last_byte;
         data_ff <= req_data_byte;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.last  = last_ff;
   assign stage.data  = data_ff;

endmodule

[design/bsch_update.sv]
module bsch_update (
   input  logic                  clock,
   input  logic                  reset,
   input  bsch_pkg::stage_type   stage,
   input  logic                  advance,
   input  logic [23:0]           poly,
   output logic [31:0]           hash_next
);
   import bsch_pkg::*;

   logic [AccWidth-1:0]  acc_ff;
   logic [AccWidth-1:0]  acc_in;
   logic [ByteWidth-1:0] idx;

   // top accumulator byte folded with the data byte picks the table entry
   assign idx       = acc_ff[AccWidth-1 -: ByteWidth] ^ stage.data;
   assign hash_next = {acc_ff[AccWidth-ByteWidth-1:0], {ByteWidth{1'b0}}}
                      ^ clmul_entry(idx, poly);

   // accumulator restarts after the last byte of a message
   always_comb begin
      acc_in = acc_ff;
      if (advance) begin
         acc_in = stage.last ? '0 : hash_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

[design/bsch_rsp_buf.sv]
module bsch_rsp_buf (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [31:0] hash_in,
   output logic        ready,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_hash_value
);
   import bsch_pkg::*;

   logic                valid_ff;
   logic                valid_in;
   logic [AccWidth-1:0] hash_ff;

   // room for a new result when empty or when the held one transfers now
   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         hash_ff <= hash_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_hash_value = hash_ff;

endmodule
